@@ rtl/htgen_pkg.sv @@
package htgen_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_TORUS_SIDE_DEF = 16;
  localparam int GHC_DIMS_DEF = 3;
  localparam int NODE_ID_BITS_DEF = 16;

  // Port numbering.
  localparam int UPLINK_PORT_BASE = 6;
  localparam int TORUS_PORTS_PER_DIM = 2;
  localparam int PORT_W = 4;

  // Field widths.
  localparam int SIDE_W = 5;      // torus side and coordinates
  localparam int HOP_W = 6;       // signed hop count
  localparam int MAG_W = 4;       // hop magnitude
  localparam int DEN_W = 15;      // divisor width (largest is side cubed)
  localparam int TOTAL_W = 7;     // ports in one route
  localparam int HC_MAX = 6;      // hypercube ports in one route
  localparam int AXES = 3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TORUS_SIDE = 3'd0;
  localparam logic [2:0] CFG_UPLINK_COUNT = 3'd1;
  localparam logic [2:0] CFG_UPLINKS_PER_SIDE = 3'd2;
  localparam logic [2:0] CFG_GHC_SIZE_X = 3'd3;
  localparam logic [2:0] CFG_GHC_SIZE_Y = 3'd4;
  localparam logic [2:0] CFG_GHC_SIZE_Z = 3'd5;

  // Register values after reset.
  localparam logic [4:0] RST_TORUS_SIDE = 5'd4;
  localparam logic [12:0] RST_UPLINK_COUNT = 13'd1;
  localparam logic [4:0] RST_UPLINKS_PER_SIDE = 5'd2;
  localparam logic [4:0] RST_GHC_SIZE = 5'd2;

  // Everything the port emitter needs for one route.
  typedef struct packed {
    logic [AXES-1:0][HOP_W-1:0] src_hops;
    logic [AXES-1:0][HOP_W-1:0] dst_hops;
    logic [HC_MAX-1:0][PORT_W-1:0] hc;
    logic [2:0] hc_len;
  } route_t;

  // Minimal signed hop count from coordinate ca to coordinate cb on a ring of n nodes.
  function automatic logic signed [HOP_W-1:0] hop(input logic [SIDE_W-1:0] ca,
                                                  input logic [SIDE_W-1:0] cb,
                                                  input logic [SIDE_W-1:0] n);
    logic signed [HOP_W:0] d;
    logic signed [HOP_W:0] half;
    logic signed [HOP_W:0] nn;
    d = $signed({2'b00, cb}) - $signed({2'b00, ca});
    half = $signed({3'b000, n[SIDE_W-1:1]});
    nn = $signed({2'b00, n});
    if (d > half) begin
      d = d - nn;
    end else if (d < -half) begin
      d = d + nn;
    end
    return d[HOP_W-1:0];
  endfunction

  // Magnitude of a hop count.
  function automatic logic [MAG_W-1:0] habs(input logic signed [HOP_W-1:0] h);
    logic signed [HOP_W-1:0] m;
    m = (h < 0) ? -h : h;
    return m[MAG_W-1:0];
  endfunction

endpackage

@@ rtl/htgen_div.sv @@
// Restoring divider, one quotient bit per cycle.
module htgen_div #(
  parameter int DW = 30,
  parameter int VW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [VW-1:0] den,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quot[DW-1]};
  assign fits = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= num;
        rem <= '0;
        cnt <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        quot <= {quot[DW-2:0], fits};
        rem <= fits ? VW'(trial - {1'b0, den}) : trial[VW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/htgen_emit.sv @@
// Walks a finished route and presents one port per transaction.
module htgen_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  htgen_pkg::route_t        route,
  input  logic                     out_ready,
  output logic                     busy,
  output logic                     out_valid,
  output logic [htgen_pkg::PORT_W-1:0] out_port,
  output logic                     out_last
);

  htgen_pkg::route_t rt;
  logic                              active;
  logic [2:0]                        seg;
  logic [htgen_pkg::MAG_W-1:0]       k;
  logic [htgen_pkg::TOTAL_W-1:0]     remaining;
  logic [htgen_pkg::TOTAL_W-1:0]     total_n;
  logic [htgen_pkg::MAG_W-1:0]       cnt;
  logic [htgen_pkg::PORT_W-1:0]      port;
  logic signed [htgen_pkg::HOP_W-1:0] h;
  logic [1:0]                        axis;
  logic                              load;

  // Number of ports of the incoming route.
  always_comb begin
    total_n = htgen_pkg::TOTAL_W'(route.hc_len);
    for (int d = 0; d < htgen_pkg::AXES; d++) begin
      total_n = total_n + htgen_pkg::TOTAL_W'(htgen_pkg::habs(route.src_hops[d]))
                        + htgen_pkg::TOTAL_W'(htgen_pkg::habs(route.dst_hops[d]));
    end
  end

  // Segments: source torus X, Y, Z, then hypercube ports, then target torus X, Y, Z.
  always_comb begin
    h = '0;
    axis = 2'd0;
    cnt = '0;
    port = '0;
    case (seg)
      3'd0, 3'd1, 3'd2: begin
        axis = seg[1:0];
        h = rt.src_hops[axis];
        cnt = htgen_pkg::habs(h);
        port = htgen_pkg::PORT_W'(htgen_pkg::TORUS_PORTS_PER_DIM * axis) + h[htgen_pkg::HOP_W-1];
      end
      3'd3: begin
        cnt = htgen_pkg::MAG_W'(rt.hc_len);
        if (k < htgen_pkg::MAG_W'(htgen_pkg::HC_MAX)) begin
          port = rt.hc[k[2:0]];
        end
      end
      3'd4, 3'd5, 3'd6: begin
        axis = 2'(seg - 3'd4);
        h = rt.dst_hops[axis];
        cnt = htgen_pkg::habs(h);
        port = htgen_pkg::PORT_W'(htgen_pkg::TORUS_PORTS_PER_DIM * axis) + h[htgen_pkg::HOP_W-1];
      end
      default: begin
        cnt = '0;
      end
    endcase
  end

  assign load = active && (!out_valid || out_ready);
  assign busy = active || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      out_valid <= 1'b0;
      seg <= '0;
      k <= '0;
      remaining <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        rt <= route;
        seg <= '0;
        k <= '0;
        remaining <= total_n;
        active <= (total_n != '0);
      end else if (load) begin
        if (k < cnt) begin
          // Emit the next port of this segment.
          out_valid <= 1'b1;
          out_port <= port;
          out_last <= (remaining == htgen_pkg::TOTAL_W'(1));
          remaining <= remaining - 1'b1;
          k <= k + 1'b1;
          if (remaining == htgen_pkg::TOTAL_W'(1)) begin
            active <= 1'b0;
          end
        end else begin
          seg <= seg + 1'b1;
          k <= '0;
        end
      end
    end
  end

endmodule

@@ rtl/hybrid_torus_hypercube_route_gen.sv @@
// Route generator for cubic 3D subtori joined by a generalized hypercube.
// Input channel (s_axis): one transaction carries a source and a target server id.
// Output channel (m_axis): one transaction per output port of the route, tlast on the
// final port. A source equal to the target gives no output transaction.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
// write only while the block is idle.
// One route at a time; s_axis_tready is high only when idle. A route spends about 6
// divisions splitting the ids into subtorus and coordinates, up to 4 more for the
// hypercube coordinates, and in the grid placement mode one more per uplink position
// along an edge, all on one shared bit-serial divider. Ports then leave at one per cycle
// while the receiver is ready, and the walk pauses when it moves to a new route segment.
// Reset is synchronous and clears the sequencer, the output register and the
// configuration registers to their defaults. When the receiver stalls, the current
// port waits in the output register and the route walk pauses.
module hybrid_torus_hypercube_route_gen #(
  parameter int MAX_TORUS_SIDE = htgen_pkg::MAX_TORUS_SIDE_DEF,
  parameter int GHC_DIMS = htgen_pkg::GHC_DIMS_DEF,
  parameter int NODE_ID_BITS = htgen_pkg::NODE_ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: source_node, target_node, zero fill.
  input  logic [((2 * NODE_ID_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0: out_port, zero fill.
  output logic [7:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int N = NODE_ID_BITS;
  localparam int IW = NODE_ID_BITS + 14;
  localparam int SW = htgen_pkg::SIDE_W;
  localparam int HW = htgen_pkg::HOP_W;
  localparam int VW = htgen_pkg::DEN_W;
  localparam int AX = htgen_pkg::AXES;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_PREP2 = 12'b000000000100,
    S_DWAIT = 12'b000000001000,
    S_MODE  = 12'b000000010000,
    S_PICK  = 12'b000000100000,
    S_GDIV  = 12'b000001000000,
    S_GFIN  = 12'b000010000000,
    S_GHC   = 12'b000100000000,
    S_ROUTE = 12'b001000000000,
    S_START = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  typedef enum logic [2:0] {
    OP_SRC, OP_DST, OP_SX, OP_SY, OP_DX, OP_DY, OP_GRID, OP_GHC
  } op_t;

  // Configuration registers.
  logic [4:0]  torus_side;
  logic [12:0] uplink_count;
  logic [4:0]  uplinks_per_side;
  logic [4:0]  ghc_size_x, ghc_size_y, ghc_size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      torus_side <= htgen_pkg::RST_TORUS_SIDE;
      uplink_count <= htgen_pkg::RST_UPLINK_COUNT;
      uplinks_per_side <= htgen_pkg::RST_UPLINKS_PER_SIDE;
      ghc_size_x <= htgen_pkg::RST_GHC_SIZE;
      ghc_size_y <= htgen_pkg::RST_GHC_SIZE;
      ghc_size_z <= htgen_pkg::RST_GHC_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        htgen_pkg::CFG_TORUS_SIDE:       torus_side <= cfg_data[4:0];
        htgen_pkg::CFG_UPLINK_COUNT:     uplink_count <= cfg_data;
        htgen_pkg::CFG_UPLINKS_PER_SIDE: uplinks_per_side <= cfg_data[4:0];
        htgen_pkg::CFG_GHC_SIZE_X:       ghc_size_x <= cfg_data[4:0];
        htgen_pkg::CFG_GHC_SIZE_Y:       ghc_size_y <= cfg_data[4:0];
        htgen_pkg::CFG_GHC_SIZE_Z:       ghc_size_z <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  state_t state;
  op_t    op;

  logic [N-1:0]   src_id, dst_id;
  logic [SW-1:0]  n_r, nh;
  logic [9:0]     n2, uu;
  logic [7:0]     nh2;
  logic [VW-1:0]  nt;
  logic [N-1:0]   ts, td;
  logic [VW-1:0]  ps, pd;
  logic [AX-1:0][SW-1:0] cs, cd;
  logic [IW-1:0]  ts_u, td_u;
  logic [AX-1:0][HW-1:0] sh, dh;
  logic [IW-1:0]  idst, v;
  logic [SW-1:0]  gi;
  logic [AX-1:0][SW-1:0] bs_i, bd_i;
  logic [IW-1:0]  sc [AX];
  logic [IW-1:0]  dc [AX];
  logic           side;
  logic [1:0]     gd;
  logic [htgen_pkg::HC_MAX-1:0][3:0] hc;
  logic [2:0]     hlen;

  // Divider interface.
  logic           div_go, div_done;
  logic [IW-1:0]  div_num, div_quot;
  logic [VW-1:0]  div_den, div_rem;

  htgen_div #(.DW(IW), .VW(VW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Side length limited to the supported range.
  logic [SW-1:0] n_clamp;
  always_comb begin
    if (torus_side < 5'd2) begin
      n_clamp = 5'd2;
    end else if (32'(torus_side) > MAX_TORUS_SIDE) begin
      n_clamp = SW'(MAX_TORUS_SIDE);
    end else begin
      n_clamp = torus_side;
    end
  end

  logic [N-1:0] in_src, in_dst;
  assign in_src = s_axis_tdata[N-1:0];
  assign in_dst = s_axis_tdata[2*N-1:N];
  assign s_axis_tready = (state == S_IDLE);

  // Placement mode decode.
  logic m_one, m_two, m_half, m_quart;
  assign m_one = (uplink_count == 13'd1);
  assign m_two = (uplink_count == 13'd2);
  assign m_half = ({1'b0, uplink_count, 1'b0} == nt);
  assign m_quart = ({uplink_count, 2'b00} == nt);

  // Uplink choice for the closed-form placement modes.
  logic [AX-1:0][HW-1:0] pk_sh, pk_dh, same_dh, corner_sh, corner_dh, ctr_sh, ctr_dh;
  logic [IW-1:0] pk_isrc, pk_idst;
  logic [5:0]    sum_cs, sum_ts, sum_cd, sum_td;
  logic          sel_s, sel_d;
  logic [1:0]    odd_s, odd_d;
  logic [11:0]   rloc_s, rloc_d;

  always_comb begin
    sum_cs = '0;
    sum_ts = '0;
    sum_cd = '0;
    sum_td = '0;
    for (int d = 0; d < AX; d++) begin
      same_dh[d] = htgen_pkg::hop(cs[d], cd[d], n_r);
      corner_sh[d] = htgen_pkg::hop(cs[d], '0, n_r);
      corner_dh[d] = htgen_pkg::hop('0, cd[d], n_r);
      ctr_sh[d] = htgen_pkg::hop(cs[d], nh, n_r);
      ctr_dh[d] = htgen_pkg::hop(nh, cd[d], n_r);
      sum_cs = sum_cs + 6'(htgen_pkg::habs(corner_sh[d]));
      sum_ts = sum_ts + 6'(htgen_pkg::habs(ctr_sh[d]));
      sum_cd = sum_cd + 6'(htgen_pkg::habs(corner_dh[d]));
      sum_td = sum_td + 6'(htgen_pkg::habs(ctr_dh[d]));
    end
    sel_s = (sum_cs > sum_ts);
    sel_d = (sum_cd > sum_td);

    // Quarter mode: coordinates of equal parity carry uplinks.
    odd_s = 2'(cs[0][0]) + 2'(cs[1][0]) + 2'(cs[2][0]);
    odd_d = 2'(cd[0][0]) + 2'(cd[1][0]) + 2'(cd[2][0]);
    rloc_s = 12'(cs[0][SW-1:1]) + 12'(nh * cs[1][SW-1:1]) + 12'(nh2 * cs[2][SW-1:1]);
    rloc_d = 12'(cd[0][SW-1:1]) + 12'(nh * cd[1][SW-1:1]) + 12'(nh2 * cd[2][SW-1:1]);

    pk_sh = '0;
    pk_dh = '0;
    if (m_one) begin
      pk_sh = corner_sh;
      pk_dh = corner_dh;
      pk_isrc = IW'(ts);
      pk_idst = IW'(td);
    end else if (m_two) begin
      pk_sh = sel_s ? ctr_sh : corner_sh;
      pk_dh = sel_d ? ctr_dh : corner_dh;
      pk_isrc = IW'({ts, sel_s});
      pk_idst = IW'({td, sel_d});
    end else if (m_half) begin
      if (src_id[0]) begin
        pk_sh[0] = {HW{1'b1}};
      end
      if (dst_id[0]) begin
        pk_dh[0] = HW'(1);
      end
      pk_isrc = IW'(src_id >> 1);
      pk_idst = IW'(dst_id >> 1);
    end else begin
      for (int d = 0; d < AX; d++) begin
        if (odd_s == 2'd1 && cs[d][0]) begin
          pk_sh[d] = {HW{1'b1}};
        end
        if (odd_s == 2'd2 && !cs[d][0]) begin
          pk_sh[d] = HW'(1);
        end
        if (odd_d == 2'd1 && cd[d][0]) begin
          pk_dh[d] = HW'(1);
        end
        if (odd_d == 2'd2 && !cd[d][0]) begin
          pk_dh[d] = {HW{1'b1}};
        end
      end
      pk_isrc = ts_u + IW'(rloc_s) + ((odd_s >= 2'd2) ? IW'(uplink_count >> 1) : '0);
      pk_idst = td_u + IW'(rloc_d) + ((odd_d >= 2'd2) ? IW'(uplink_count >> 1) : '0);
    end
  end

  // Grid mode: one candidate position per divider result, all three axes at once.
  logic [SW-1:0] grid_q;
  logic [AX-1:0][HW-1:0] cand_s, cand_d;
  assign grid_q = div_quot[SW-1:0];
  always_comb begin
    for (int d = 0; d < AX; d++) begin
      cand_s[d] = htgen_pkg::hop(cs[d], grid_q, n_r);
      cand_d[d] = htgen_pkg::hop(grid_q, cd[d], n_r);
    end
  end

  logic [VW-1:0] a_s, a_d;
  assign a_s = VW'(bs_i[0]) + VW'(bs_i[1] * uplinks_per_side) + VW'(bs_i[2] * uu);
  assign a_d = VW'(bd_i[0]) + VW'(bd_i[1] * uplinks_per_side) + VW'(bd_i[2] * uu);

  // Hypercube size of the dimension in progress, zero taken as one.
  logic [SW-1:0] gsel;
  always_comb begin
    case (gd)
      2'd0: gsel = ghc_size_x;
      2'd1: gsel = ghc_size_y;
      default: gsel = ghc_size_z;
    endcase
    if (gsel == '0) begin
      gsel = SW'(1);
    end
  end

  // Hypercube hops: uplink port then switch port for each differing dimension.
  logic [htgen_pkg::HC_MAX-1:0][3:0] hc_n;
  logic [2:0] len_n;
  always_comb begin
    hc_n = '0;
    len_n = '0;
    for (int d = 0; d < GHC_DIMS; d++) begin
      if (sc[d] != dc[d]) begin
        hc_n[len_n] = 4'(htgen_pkg::UPLINK_PORT_BASE + d);
        hc_n[3'(len_n + 3'd1)] = dc[d][3:0];
        len_n = len_n + 3'd2;
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_go <= 1'b0;
      op <= OP_SRC;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            src_id <= in_src;
            dst_id <= in_dst;
            n_r <= n_clamp;
            nh <= n_clamp >> 1;
            if (in_src != in_dst) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          n2 <= 10'(n_r * n_r);
          nh2 <= 8'(nh * nh);
          state <= S_PREP2;
        end
        S_PREP2: begin
          nt <= VW'(n2 * n_r);
          uu <= 10'(uplinks_per_side * uplinks_per_side);
          div_go <= 1'b1;
          op <= OP_SRC;
          div_num <= IW'(src_id);
          div_den <= VW'(n2 * n_r);
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (op)
              OP_SRC: begin
                ts <= div_quot[N-1:0];
                ps <= div_rem;
                div_go <= 1'b1;
                op <= OP_DST;
                div_num <= IW'(dst_id);
                div_den <= nt;
              end
              OP_DST: begin
                td <= div_quot[N-1:0];
                pd <= div_rem;
                div_go <= 1'b1;
                op <= OP_SX;
                div_num <= IW'(ps);
                div_den <= VW'(n_r);
              end
              OP_SX: begin
                cs[0] <= div_rem[SW-1:0];
                div_go <= 1'b1;
                op <= OP_SY;
                div_num <= div_quot;
              end
              OP_SY: begin
                cs[1] <= div_rem[SW-1:0];
                cs[2] <= div_quot[SW-1:0];
                div_go <= 1'b1;
                op <= OP_DX;
                div_num <= IW'(pd);
              end
              OP_DX: begin
                cd[0] <= div_rem[SW-1:0];
                div_go <= 1'b1;
                op <= OP_DY;
                div_num <= div_quot;
              end
              OP_DY: begin
                cd[1] <= div_rem[SW-1:0];
                cd[2] <= div_quot[SW-1:0];
                state <= S_MODE;
              end
              OP_GRID: begin
                // Keep the first strictly closer position along each axis.
                for (int d = 0; d < AX; d++) begin
                  if (htgen_pkg::habs(cand_s[d]) < htgen_pkg::habs(sh[d])) begin
                    sh[d] <= cand_s[d];
                    bs_i[d] <= gi;
                  end
                  if (htgen_pkg::habs(cand_d[d]) < htgen_pkg::habs(dh[d])) begin
                    dh[d] <= cand_d[d];
                    bd_i[d] <= gi;
                  end
                end
                gi <= gi + 1'b1;
                if ({1'b0, gi} + 6'd1 == {1'b0, uplinks_per_side}) begin
                  state <= S_GFIN;
                end else begin
                  state <= S_GDIV;
                end
              end
              OP_GHC: begin
                if (!side) begin
                  sc[gd] <= IW'(div_rem);
                end else begin
                  dc[gd] <= IW'(div_rem);
                end
                v <= div_quot;
                gd <= gd + 1'b1;
                state <= S_GHC;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MODE: begin
          ts_u <= IW'(ts * uplink_count);
          td_u <= IW'(td * uplink_count);
          state <= S_PICK;
        end
        S_PICK: begin
          side <= 1'b0;
          gd <= '0;
          if (ts == td) begin
            sh <= '0;
            dh <= same_dh;
            hlen <= '0;
            state <= S_START;
          end else if (!m_one && !m_two && !m_half && !m_quart) begin
            sh <= corner_sh;
            dh <= corner_dh;
            bs_i <= '0;
            bd_i <= '0;
            gi <= '0;
            state <= (uplinks_per_side == '0) ? S_GFIN : S_GDIV;
          end else begin
            sh <= pk_sh;
            dh <= pk_dh;
            v <= pk_isrc;
            idst <= pk_idst;
            state <= S_GHC;
          end
        end
        S_GDIV: begin
          div_go <= 1'b1;
          op <= OP_GRID;
          div_num <= IW'(gi * n_r);
          div_den <= VW'(uplinks_per_side);
          state <= S_DWAIT;
        end
        S_GFIN: begin
          v <= ts_u + IW'(a_s);
          idst <= td_u + IW'(a_d);
          side <= 1'b0;
          gd <= '0;
          state <= S_GHC;
        end
        S_GHC: begin
          if (32'(gd) < GHC_DIMS - 1) begin
            div_go <= 1'b1;
            op <= OP_GHC;
            div_num <= v;
            div_den <= VW'(gsel);
            state <= S_DWAIT;
          end else if (!side) begin
            sc[gd] <= v;
            side <= 1'b1;
            gd <= '0;
            v <= idst;
          end else begin
            dc[gd] <= v;
            state <= S_ROUTE;
          end
        end
        S_ROUTE: begin
          hc <= hc_n;
          hlen <= len_n;
          state <= S_START;
        end
        S_START: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Port emitter with its output register.
  htgen_pkg::route_t route;
  logic emit_busy;
  logic [htgen_pkg::PORT_W-1:0] out_port;

  assign route.src_hops = sh;
  assign route.dst_hops = dh;
  assign route.hc = hc;
  assign route.hc_len = hlen;

  htgen_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .route    (route),
    .out_ready(m_axis_tready),
    .busy     (emit_busy),
    .out_valid(m_axis_tvalid),
    .out_port (out_port),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_port};

endmodule

@@ tb/sv/hybrid_torus_hypercube_route_gen_tb.sv @@
module hybrid_torus_hypercube_route_gen_tb;
  import htgen_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 2000;

  typedef int hop3_t [3];

  // One expected output port of a route.
  typedef struct {
    logic [3:0] port;
    logic last;
  } port_exp_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // Fields from bit 0: source_node, target_node.
  logic [31:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // Fields from bit 0: out_port, zero fill.
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [12:0] cfg_data;

  // Shadow copy of the configuration registers.
  int side_reg, uplink_reg, per_side_reg, gsize_x, gsize_y, gsize_z;

  logic [31:0] pending_routes[$];
  port_exp_t expected_ports[$];
  int errors;
  int gap_left, burst_left;
  logic nxt_valid;
  logic [31:0] nxt_data;
  int stall_mode, stall_left;
  int idle_cycles;

  hybrid_torus_hypercube_route_gen DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Minimal signed ring hops from server a to server b, per axis.
  function automatic hop3_t ring_hops(longint n, longint a, longint b);
    hop3_t h;
    longint d;
    for (int i = 0; i < 3; i++) begin
      d = (b % n) - (a % n);
      a = a / n;
      b = b / n;
      if (d > n / 2) d = d - n;
      else if (d < -(n / 2)) d = d + n;
      h[i] = int'(d);
    end
    return h;
  endfunction

  function automatic int hop_total(hop3_t h);
    int s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (h[i] < 0) ? -h[i] : h[i];
    return s;
  endfunction

  // Quarter placement: nodes whose coordinates share parity carry uplinks.
  function automatic longint quarter_uplink(longint n, longint ucnt, longint id, int dir,
                                            output hop3_t h);
    longint nt, t, pos, r;
    longint c[3];
    int odd;
    nt = n * n * n;
    t = id / nt;
    pos = id % nt;
    c[0] = pos % n;
    c[1] = (pos / n) % n;
    c[2] = (pos / n / n) % n;
    odd = 0;
    for (int i = 0; i < 3; i++) odd += int'(c[i] & 1);
    for (int i = 0; i < 3; i++) begin
      h[i] = 0;
      if (odd == 1 && (c[i] & 1) != 0) h[i] = dir;
      if (odd == 2 && (c[i] & 1) == 0) h[i] = -dir;
    end
    r = t * ucnt + c[0] / 2 + (n / 2) * (c[1] / 2) + (n / 2) * (n / 2) * (c[2] / 2);
    if (odd >= 2) r += ucnt / 2;
    return r;
  endfunction

  // Grid placement: nearest grid node, ties keep the earlier candidate.
  function automatic longint grid_uplink(longint n, longint ucnt, longint id, bit to_node,
                                         output hop3_t h);
    longint nt, t, base, u, a, cand;
    hop3_t tt;
    nt = n * n * n;
    t = id / nt;
    base = t * nt;
    u = per_side_reg;
    a = 0;
    h = to_node ? ring_hops(n, base, id) : ring_hops(n, id, base);
    for (longint i = 0; i < u; i++)
      for (longint j = 0; j < u; j++)
        for (longint k = 0; k < u; k++) begin
          cand = base + (i * n) / u + ((j * n) / u) * n + ((k * n) / u) * n * n;
          tt = to_node ? ring_hops(n, cand, id) : ring_hops(n, id, cand);
          if (hop_total(h) > hop_total(tt)) begin
            h = tt;
            a = i + j * u + k * u * u;
          end
        end
    return t * ucnt + a;
  endfunction

  // Two-uplink placement: corner or centre of the server's own subtorus.
  function automatic longint pair_uplink(longint n, longint id, bit to_node,
                                         output hop3_t h);
    longint nt, t, base, ctr;
    hop3_t tt;
    nt = n * n * n;
    t = id / nt;
    base = t * nt;
    ctr = base + n / 2 + (n / 2) * n + (n / 2) * n * n;
    h = to_node ? ring_hops(n, base, id) : ring_hops(n, id, base);
    tt = to_node ? ring_hops(n, ctr, id) : ring_hops(n, id, ctr);
    if (hop_total(h) > hop_total(tt)) begin
      h = tt;
      return 2 * t + 1;
    end
    return 2 * t;
  endfunction

  task automatic push_torus_ports(hop3_t h);
    port_exp_t e;
    int m;
    for (int d = 0; d < 3; d++) begin
      m = (h[d] < 0) ? -h[d] : h[d];
      e.port = 4'(TORUS_PORTS_PER_DIM * d + ((h[d] < 0) ? 1 : 0));
      e.last = 1'b0;
      for (int k = 0; k < m; k++) expected_ports.push_back(e);
    end
  endtask

  // Work out the full port sequence of one route and queue it.
  task automatic route_predict(longint src, longint dst);
    longint n, nt, ucnt, isrc, idst, v;
    longint g[3], sc[3], dc[3];
    hop3_t sh, dh;
    port_exp_t e;
    int first;
    n = side_reg;
    if (n < 2) n = 2;
    if (n > 16) n = 16;
    nt = n * n * n;
    ucnt = uplink_reg;
    first = expected_ports.size();
    sh = '{0, 0, 0};
    dh = '{0, 0, 0};
    if (src == dst) return;
    if (src / nt == dst / nt) begin
      dh = ring_hops(n, src, dst);
      push_torus_ports(dh);
    end else begin
      if (ucnt == 1) begin
        isrc = src / nt;
        idst = dst / nt;
        sh = ring_hops(n, src, isrc * nt);
        dh = ring_hops(n, idst * nt, dst);
      end else if (ucnt == 2) begin
        isrc = pair_uplink(n, src, 1'b0, sh);
        idst = pair_uplink(n, dst, 1'b1, dh);
      end else if (2 * ucnt == nt) begin
        if (src & 1) sh[0] = -1;
        if (dst & 1) dh[0] = 1;
        isrc = src / 2;
        idst = dst / 2;
      end else if (4 * ucnt == nt) begin
        isrc = quarter_uplink(n, ucnt, src, -1, sh);
        idst = quarter_uplink(n, ucnt, dst, 1, dh);
      end else begin
        isrc = grid_uplink(n, ucnt, src, 1'b0, sh);
        idst = grid_uplink(n, ucnt, dst, 1'b1, dh);
      end
      g[0] = gsize_x ? gsize_x : 1;
      g[1] = gsize_y ? gsize_y : 1;
      g[2] = gsize_z ? gsize_z : 1;
      // The last hypercube coordinate keeps whatever is left of the position.
      v = isrc;
      sc[0] = v % g[0]; v = v / g[0];
      sc[1] = v % g[1]; v = v / g[1];
      sc[2] = v;
      v = idst;
      dc[0] = v % g[0]; v = v / g[0];
      dc[1] = v % g[1]; v = v / g[1];
      dc[2] = v;
      push_torus_ports(sh);
      for (int d = 0; d < 3; d++) begin
        if (sc[d] != dc[d]) begin
          e.last = 1'b0;
          e.port = 4'(UPLINK_PORT_BASE + d);
          expected_ports.push_back(e);
          e.port = 4'(dc[d] & 15);
          expected_ports.push_back(e);
        end
      end
      push_torus_ports(dh);
    end
    if (expected_ports.size() > first)
      expected_ports[expected_ports.size() - 1].last = 1'b1;
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        route_predict(longint'(s_axis_tdata[15:0]), longint'(s_axis_tdata[31:16]));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_routes.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt_data = pending_routes.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata <= nxt_data;
    end
  end

  // Receiver: checks each port transaction and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_ports.size() == 0) begin
          $display("%0t: unexpected port %0d last %0b", $time, m_axis_tdata[3:0],
                   m_axis_tlast);
          errors++;
        end else begin
          port_exp_t e;
          e = expected_ports.pop_front();
          if (m_axis_tdata[3:0] !== e.port || m_axis_tlast !== e.last) begin
            $display("%0t: port mismatch: expected port %0d last %0b, got port %0d last %0b",
                     $time, e.port, e.last, m_axis_tdata[3:0], m_axis_tlast);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= $urandom_range(0, 1);
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_axis_tready <= (stall_left % 16) >= 5;
        end
      endcase
    end
  end

  // Watchdog on cycles with work outstanding but no transaction.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_routes.size() == 0 && !s_axis_tvalid && expected_ports.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    for (int pass = 0; pass < 2; pass++) begin
      while (!(pending_routes.size() == 0 && !s_axis_tvalid && expected_ports.size() == 0
               && s_axis_tready))
        @(posedge clk);
      repeat (200) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(val);
    case (idx)
      CFG_TORUS_SIDE: side_reg = val;
      CFG_UPLINK_COUNT: uplink_reg = val;
      CFG_UPLINKS_PER_SIDE: per_side_reg = val;
      CFG_GHC_SIZE_X: gsize_x = val;
      CFG_GHC_SIZE_Y: gsize_y = val;
      default: gsize_z = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_route(int src, int dst);
    pending_routes.push_back({16'(dst), 16'(src)});
  endtask

  // Random routes: mostly across subtori, some inside one, a few to itself.
  task automatic push_random(int count);
    int nt, src, dst, sel;
    nt = side_reg * side_reg * side_reg;
    for (int i = 0; i < count; i++) begin
      src = $urandom_range(0, 65535);
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        dst = src;
      end else if (sel <= 3) begin
        dst = (src / nt) * nt + $urandom_range(0, nt - 1);
        if (dst > 65535) dst = 65535;
      end else begin
        dst = $urandom_range(0, 65535);
      end
      push_route(src, dst);
    end
  endtask

  task automatic run_phase(int side, int ucnt, int per_side, int gx, int gy, int gz,
                           int nrand);
    wait_drained();
    cfg_write(CFG_TORUS_SIDE, side);
    cfg_write(CFG_UPLINK_COUNT, ucnt);
    cfg_write(CFG_UPLINKS_PER_SIDE, per_side);
    cfg_write(CFG_GHC_SIZE_X, gx);
    cfg_write(CFG_GHC_SIZE_Y, gy);
    cfg_write(CFG_GHC_SIZE_Z, gz);
    // Corner ids in both directions, and the last server to server 0 in the same subtorus.
    push_route(0, 65535);
    push_route(65535, 0);
    push_route(side * side * side - 1, 0);
    push_random(nrand);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TORUS_SIDE;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    side_reg = RST_TORUS_SIDE;
    uplink_reg = RST_UPLINK_COUNT;
    per_side_reg = RST_UPLINKS_PER_SIDE;
    gsize_x = RST_GHC_SIZE;
    gsize_y = RST_GHC_SIZE;
    gsize_z = RST_GHC_SIZE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: one uplink per subtorus.
    push_route(5, 5);
    push_route(0, 63);
    push_route(0, 64);
    push_route(42, 65535 - 21);
    push_random(20);
    // Pause until the routes so far have all come out, then continue.
    wait_drained();
    push_random(20);

    // Two uplinks on the smallest subtorus, single-width GHC in two dimensions.
    run_phase(2, 2, 1, 1, 1, 16, 42);
    // Half of the servers uplinked.
    run_phase(4, 32, 3, 16, 1, 2, 42);
    // A quarter of the servers uplinked.
    run_phase(4, 16, 2, 3, 5, 7, 42);
    // Largest subtorus and grid, every node an uplink candidate.
    run_phase(16, 4096, 16, 16, 16, 16, 40);
    // Largest subtorus, one uplink, longest torus legs.
    run_phase(16, 1, 1, 4, 2, 1, 42);
    // Grid with a single node per edge, and an odd side with an uneven grid.
    run_phase(8, 5, 1, 2, 3, 4, 42);
    run_phase(5, 3, 3, 7, 2, 9, 42);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
